// ----- rtl/lod_pkg.sv -----
// Shared constants and types of the lock order deadlock checker.
`timescale 1ns / 1ps

package lod_pkg;

    localparam int LOCKS_DEFAULT = 16;
    localparam int STACK_DEFAULT = 16;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CYCLE    = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_HALTED   = 3'd5;

    // Completion report of the graph engine
    typedef struct packed {
        logic done;
        logic cycle;
    } t_gstat;

endpackage

// ----- rtl/lod_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module lod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lod_graph.sv -----
// Lock order graph: edge store and iterative depth-first cycle search.
`timescale 1ns / 1ps

module lod_graph #(
    parameter int NUM_LOCKS = lod_pkg::LOCKS_DEFAULT,
    localparam int LW = $clog2(NUM_LOCKS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [LW-1:0]  i_from,
    input  logic [LW-1:0]  i_to,
    output lod_pkg::t_gstat o_stat,
    output logic [LW-1:0]  o_cycle_from,
    output logic [LW-1:0]  o_cycle_to
);

    localparam int CWID = $clog2(NUM_LOCKS + 1);
    localparam int SSW  = LW + CWID;

    typedef enum logic [5:0] {
        G_IDLE  = 6'b000001,
        G_RDROW = 6'b000010,
        G_ROOT  = 6'b000100,
        G_LOAD  = 6'b001000,
        G_SCAN  = 6'b010000,
        G_POP   = 6'b100000
    } t_gstate;

    t_gstate r_state, n_state;
    logic [LW-1:0]        r_from, n_from;
    logic [LW-1:0]        r_to, n_to;
    logic [CWID-1:0]      r_root, n_root;
    logic [LW-1:0]        r_u, n_u;
    logic [CWID-1:0]      r_c, n_c;
    logic [LW-1:0]        r_depth, n_depth;
    logic [NUM_LOCKS-1:0] r_row, n_row;
    logic [NUM_LOCKS-1:0] r_seen, n_seen;
    logic [NUM_LOCKS-1:0] r_onpath, n_onpath;
    logic [NUM_LOCKS-1:0] r_row_vld, n_row_vld;
    logic                 r_rd_vld;
    logic                 r_done, n_done;
    logic                 r_cycle, n_cycle;
    logic [LW-1:0]        r_cfrom, n_cfrom;
    logic [LW-1:0]        r_cto, n_cto;

    logic                 e_we, e_re;
    logic [LW-1:0]        e_waddr, e_raddr;
    logic [NUM_LOCKS-1:0] e_wdata, e_rdata, w_row;
    logic                 s_we, s_re;
    logic [LW-1:0]        s_waddr, s_raddr;
    logic [SSW-1:0]       s_wdata, s_rdata;
    logic [LW-1:0]        w_cidx, w_pop_u;

    lod_ram #(.WIDTH(NUM_LOCKS), .DEPTH(NUM_LOCKS)) u_edges (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    lod_ram #(.WIDTH(SSW), .DEPTH(NUM_LOCKS)) u_dfs_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // rows never written read as empty
    assign w_row   = r_rd_vld ? e_rdata : '0;
    assign w_cidx  = r_c[LW-1:0];
    assign w_pop_u = s_rdata[SSW-1 -: LW];

    always_comb begin
        n_state   = r_state;
        n_from    = r_from;
        n_to      = r_to;
        n_root    = r_root;
        n_u       = r_u;
        n_c       = r_c;
        n_depth   = r_depth;
        n_row     = r_row;
        n_seen    = r_seen;
        n_onpath  = r_onpath;
        n_row_vld = r_row_vld;
        n_done    = 1'b0;
        n_cycle   = r_cycle;
        n_cfrom   = r_cfrom;
        n_cto     = r_cto;
        e_we      = 1'b0;
        e_waddr   = r_from;
        e_wdata   = w_row | (NUM_LOCKS'(1) << r_to);
        e_re      = 1'b0;
        e_raddr   = r_from;
        s_we      = 1'b0;
        s_waddr   = r_depth;
        s_wdata   = {r_u, r_c + CWID'(1)};
        s_re      = 1'b0;
        s_raddr   = r_depth - LW'(1);
        unique case (r_state)
            G_IDLE: begin
                if (i_start) begin
                    n_from  = i_from;
                    n_to    = i_to;
                    e_re    = 1'b1;
                    e_raddr = i_from;
                    n_state = G_RDROW;
                end
            end
            G_RDROW: begin
                if (w_row[r_to]) begin
                    // edge already known: no search
                    n_done  = 1'b1;
                    n_cycle = 1'b0;
                    n_state = G_IDLE;
                end else begin
                    e_we              = 1'b1;
                    n_row_vld[r_from] = 1'b1;
                    n_root            = '0;
                    n_seen            = '0;
                    n_onpath          = '0;
                    n_state           = G_ROOT;
                end
            end
            G_ROOT: begin
                if (r_root == CWID'(NUM_LOCKS)) begin
                    n_done  = 1'b1;
                    n_cycle = 1'b0;
                    n_state = G_IDLE;
                end else if (r_seen[r_root[LW-1:0]]) begin
                    n_root = r_root + CWID'(1);
                end else begin
                    n_seen[r_root[LW-1:0]]   = 1'b1;
                    n_onpath[r_root[LW-1:0]] = 1'b1;
                    n_u     = r_root[LW-1:0];
                    n_c     = '0;
                    n_depth = '0;
                    e_re    = 1'b1;
                    e_raddr = r_root[LW-1:0];
                    n_root  = r_root + CWID'(1);
                    n_state = G_LOAD;
                end
            end
            G_LOAD: begin
                n_row   = w_row;
                n_state = G_SCAN;
            end
            G_SCAN: begin
                if (r_c == CWID'(NUM_LOCKS)) begin
                    n_onpath[r_u] = 1'b0;
                    if (r_depth == '0) begin
                        n_state = G_ROOT;
                    end else begin
                        s_re    = 1'b1;
                        n_state = G_POP;
                    end
                end else begin
                    n_c = r_c + CWID'(1);
                    if (r_row[w_cidx]) begin
                        if (!r_seen[w_cidx]) begin
                            // descend; parent resumes at the next neighbour
                            s_we             = 1'b1;
                            n_depth          = r_depth + LW'(1);
                            n_seen[w_cidx]   = 1'b1;
                            n_onpath[w_cidx] = 1'b1;
                            n_u              = w_cidx;
                            n_c              = '0;
                            e_re             = 1'b1;
                            e_raddr          = w_cidx;
                            n_state          = G_LOAD;
                        end else if (r_onpath[w_cidx]) begin
                            // back edge into the current path
                            n_done  = 1'b1;
                            n_cycle = 1'b1;
                            n_cfrom = r_u;
                            n_cto   = w_cidx;
                            n_state = G_IDLE;
                        end
                    end
                end
            end
            G_POP: begin
                n_u     = w_pop_u;
                n_c     = s_rdata[CWID-1:0];
                n_depth = r_depth - LW'(1);
                e_re    = 1'b1;
                e_raddr = w_pop_u;
                n_state = G_LOAD;
            end
            default: begin
                n_state = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= G_IDLE;
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_seen    <= '0;
            r_onpath  <= '0;
            r_done    <= 1'b0;
            r_cycle   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row_vld <= n_row_vld;
            if (e_re) begin
                r_rd_vld <= r_row_vld[e_raddr];
            end
            r_seen    <= n_seen;
            r_onpath  <= n_onpath;
            r_done    <= n_done;
            r_cycle   <= n_cycle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from  <= n_from;
        r_to    <= n_to;
        r_root  <= n_root;
        r_u     <= n_u;
        r_c     <= n_c;
        r_depth <= n_depth;
        r_row   <= n_row;
        r_cfrom <= n_cfrom;
        r_cto   <= n_cto;
    end

    assign o_stat.done  = r_done;
    assign o_stat.cycle = r_cycle;
    assign o_cycle_from = r_cfrom;
    assign o_cycle_to   = r_cto;

`ifndef SYNTHESIS
    a_path_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_onpath & ~r_seen) == '0)
        else $error("lock on search path but not marked seen");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("search completion held for more than one cycle");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == G_IDLE)
        else $error("search started while engine busy");

    a_cycle_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_cycle |-> r_onpath[r_cfrom] && r_onpath[r_cto])
        else $error("reported back edge does not lie on the search path");
`endif

endmodule

// ----- rtl/lock_order_deadlock_checker_top.sv -----
// Top level of the lock order deadlock checker: held-lock stack and item sequencing.
`timescale 1ns / 1ps
// Usage
//   Input channel: i_valid / o_stall with i_cmd (0 acquire, 1 release) and
//   i_lock_id. An item is taken at an edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_status, o_cycle_from,
//   o_cycle_to; exactly one result per item.
// Sequencing
//   One item at a time: o_stall is high from acceptance until its result
//   has been taken. A halted item goes straight to its result; a release,
//   or an acquire on an empty stack or of the lock on top, first reads the
//   stack top; an acquire whose order edge is already known also reads the
//   edge row in the graph engine. A new edge runs the depth-first search in
//   the graph engine, which tests one neighbour per cycle between row loads
//   and stack pops. After a taken result the block returns to idle before
//   it takes a new item.
// Stall
//   A stalled result holds its value and the block takes no new item.
// Reset
//   i_rst_n (synchronous, active low) empties the lock stack, clears the
//   order graph and the sticky halt. After any fault every item answers
//   halted until the next reset.

module lock_order_deadlock_checker_top #(
    parameter int NUM_LOCKS   = lod_pkg::LOCKS_DEFAULT,
    parameter int STACK_DEPTH = lod_pkg::STACK_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [3:0] i_lock_id,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [3:0] o_cycle_from,
    output logic [3:0] o_cycle_to
);

    localparam int LW = $clog2(NUM_LOCKS);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [3:0] MOD_STEP = 4'(NUM_LOCKS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TOP   = 4'b0010,
        S_GRAPH = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic          r_cmd, n_cmd;
    logic [LW-1:0] r_id, n_id;
    logic [CW-1:0] r_count, n_count;
    logic          r_halt, n_halt;
    logic [2:0]    r_status, n_status;
    logic [3:0]    r_cfrom, n_cfrom;
    logic [3:0]    r_cto, n_cto;

    logic          w_accept;
    logic [3:0]    w_mod;
    logic [LW-1:0] w_id;
    logic [CW-1:0] w_cnt_m1;
    logic          w_full;
    logic          h_we, h_re;
    logic [LW-1:0] h_rdata;
    logic          g_start;
    lod_pkg::t_gstat w_gstat;
    logic [LW-1:0] g_cfrom, g_cto;

    assign w_accept = i_valid && !o_stall;
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_full   = r_count >= CW'(STACK_DEPTH);

    // lock id modulo the lock count by repeated subtraction
    always_comb begin
        w_mod = i_lock_id;
        for (int k = 0; k < 8; k++) begin
            if (int'(w_mod) >= NUM_LOCKS) begin
                w_mod = w_mod - MOD_STEP;
            end
        end
        w_id = LW'(w_mod);
    end

    lod_ram #(.WIDTH(LW), .DEPTH(STACK_DEPTH)) u_held (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (r_count[SW-1:0]),
        .i_wdata (r_id),
        .i_re    (h_re),
        .i_raddr (w_cnt_m1[SW-1:0]),
        .o_rdata (h_rdata)
    );

    lod_graph #(.NUM_LOCKS(NUM_LOCKS)) u_graph (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (g_start),
        .i_from       (h_rdata),
        .i_to         (r_id),
        .o_stat       (w_gstat),
        .o_cycle_from (g_cfrom),
        .o_cycle_to   (g_cto)
    );

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_id     = r_id;
        n_count  = r_count;
        n_halt   = r_halt;
        n_status = r_status;
        n_cfrom  = r_cfrom;
        n_cto    = r_cto;
        h_we     = 1'b0;
        h_re     = 1'b0;
        g_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_cmd;
                    n_id    = w_id;
                    h_re    = 1'b1;
                    n_cfrom = '0;
                    n_cto   = '0;
                    if (r_halt) begin
                        n_status = lod_pkg::ST_HALTED;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_TOP;
                    end
                end
            end
            S_TOP: begin
                n_state  = S_OUT;
                n_status = lod_pkg::ST_OK;
                if (r_cmd == lod_pkg::CMD_ACQUIRE) begin
                    if (r_count != '0 && h_rdata != r_id) begin
                        g_start = 1'b1;
                        n_state = S_GRAPH;
                    end else if (w_full) begin
                        n_status = lod_pkg::ST_FULL;
                        n_halt   = 1'b1;
                    end else begin
                        h_we    = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    if (r_count == '0) begin
                        n_status = lod_pkg::ST_EMPTY;
                        n_halt   = 1'b1;
                    end else if (h_rdata != r_id) begin
                        n_status = lod_pkg::ST_MISMATCH;
                        n_halt   = 1'b1;
                    end else begin
                        n_count = w_cnt_m1;
                    end
                end
            end
            S_GRAPH: begin
                if (w_gstat.done) begin
                    n_state = S_OUT;
                    if (w_gstat.cycle) begin
                        n_status = lod_pkg::ST_CYCLE;
                        n_halt   = 1'b1;
                        n_cfrom  = 4'(g_cfrom);
                        n_cto    = 4'(g_cto);
                    end else if (w_full) begin
                        n_status = lod_pkg::ST_FULL;
                        n_halt   = 1'b1;
                    end else begin
                        h_we    = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_halt  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_id     <= n_id;
        r_status <= n_status;
        r_cfrom  <= n_cfrom;
        r_cto    <= n_cto;
    end

    assign o_stall      = r_state != S_IDLE;
    assign o_valid      = r_state == S_OUT;
    assign o_status     = r_status;
    assign o_cycle_from = r_cfrom;
    assign o_cycle_to   = r_cto;

`ifndef SYNTHESIS
    a_halted_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_halt |=> o_valid && o_status == lod_pkg::ST_HALTED)
        else $error("item after a fault not answered as halted");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("held lock count beyond stack depth");

    a_cycle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != lod_pkg::ST_CYCLE |-> o_cycle_from == '0 && o_cycle_to == '0)
        else $error("cycle locks reported without a cycle");

    a_graph_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gstat.done |-> r_state == S_GRAPH)
        else $error("search finished while no item waits on it");

    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != lod_pkg::ST_OK |-> r_halt)
        else $error("fault reported without sticky halt");
`endif

endmodule

// ----- dv/lod_order_checker.sv -----
// Scoreboard for the lock order checker: mirrors the held-lock stack and order graph.
`timescale 1ns / 1ps

module lod_order_checker
    import lod_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic        i_cmd,
    input  logic [3:0]  i_lock_id,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [2:0]  i_status,
    input  logic [3:0]  i_cycle_from,
    input  logic [3:0]  i_cycle_to,
    output int unsigned o_fail_count,
    output int unsigned o_waiting,
    output int unsigned o_checked
);

    localparam int NUM_LOCKS   = LOCKS_DEFAULT;
    localparam int STACK_DEPTH = STACK_DEFAULT;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] from_id;
        logic [3:0] to_id;
    } t_verdict;

    logic [NUM_LOCKS-1:0] order_graph [NUM_LOCKS];
    logic [3:0]           held_ids [STACK_DEPTH];
    int unsigned          held_depth;
    bit                   halted;
    t_verdict             expected_verdicts [$];

    // DFS over every root in ascending order; first back edge into an unfinished node wins
    function automatic bit find_back_edge(output logic [3:0] src, output logic [3:0] dst);
        logic [NUM_LOCKS-1:0] seen;
        int unsigned          stamp [NUM_LOCKS];
        bit                   finished [NUM_LOCKS];
        int unsigned          path [NUM_LOCKS];
        int unsigned          cursor [NUM_LOCKS];
        int unsigned          count;
        int unsigned          depth;
        int unsigned          u;
        int unsigned          c;
        seen  = '0;
        count = 0;
        src   = '0;
        dst   = '0;
        for (int r = 0; r < NUM_LOCKS; r++) begin
            if (seen[r])
                continue;
            seen[r]     = 1'b1;
            stamp[r]    = count;
            count++;
            finished[r] = 1'b0;
            path[0]     = r;
            cursor[0]   = 0;
            depth       = 1;
            while (depth > 0) begin
                u = path[depth-1];
                c = cursor[depth-1];
                if (c >= NUM_LOCKS) begin
                    finished[u] = 1'b1;
                    depth--;
                    continue;
                end
                cursor[depth-1] = c + 1;
                if (!order_graph[u][c])
                    continue;
                if (!seen[c]) begin
                    seen[c]       = 1'b1;
                    stamp[c]      = count;
                    count++;
                    finished[c]   = 1'b0;
                    path[depth]   = c;
                    cursor[depth] = 0;
                    depth++;
                    continue;
                end
                if (stamp[u] < stamp[c])
                    continue;
                if (!finished[c]) begin
                    src = 4'(u);
                    dst = 4'(c);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_verdict predict_lock_op(input logic cmd, input logic [3:0] id);
        t_verdict   v;
        logic [3:0] prev;
        logic [3:0] src;
        logic [3:0] dst;
        bit         loop_found;
        v          = '0;
        v.status   = ST_OK;
        loop_found = 1'b0;
        if (halted) begin
            v.status = ST_HALTED;
        end else if (cmd == CMD_ACQUIRE) begin
            if (held_depth > 0) begin
                prev = held_ids[held_depth-1];
                // recursive acquire and known edges skip the search
                if (prev != id && !order_graph[prev][id]) begin
                    order_graph[prev][id] = 1'b1;
                    loop_found = find_back_edge(src, dst);
                end
            end
            if (loop_found) begin
                v.status  = ST_CYCLE;
                v.from_id = src;
                v.to_id   = dst;
                halted    = 1'b1;
            end else if (held_depth >= STACK_DEPTH) begin
                v.status = ST_FULL;
                halted   = 1'b1;
            end else begin
                held_ids[held_depth] = id;
                held_depth++;
            end
        end else begin
            if (held_depth == 0) begin
                v.status = ST_EMPTY;
                halted   = 1'b1;
            end else if (held_ids[held_depth-1] != id) begin
                v.status = ST_MISMATCH;
                halted   = 1'b1;
            end else begin
                held_depth--;
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            for (int f = 0; f < NUM_LOCKS; f++)
                order_graph[f] = '0;
            held_depth = 0;
            halted     = 1'b0;
            expected_verdicts.delete();
            o_fail_count = 0;
            o_waiting    = 0;
            o_checked    = 0;
        end else begin
            if (i_valid && !i_in_stall)
                expected_verdicts.push_back(predict_lock_op(i_cmd, i_lock_id));
            if (i_res_valid && !i_res_stall) begin
                if (expected_verdicts.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with none expected: status %0d from %0d to %0d",
                                 $realtime, i_status, i_cycle_from, i_cycle_to);
                end else begin
                    want = expected_verdicts.pop_front();
                    o_checked++;
                    if (want.status !== i_status || want.from_id !== i_cycle_from ||
                        want.to_id !== i_cycle_to) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: exp status %0d from %0d to %0d, got %0d from %0d to %0d",
                                     $realtime, want.status, want.from_id, want.to_id,
                                     i_status, i_cycle_from, i_cycle_to);
                    end
                end
            end
            o_waiting = expected_verdicts.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top: drives nested lock traffic into the deadlock checker and gives the verdict.
`timescale 1ns / 1ps

module tb_top;

    import lod_pkg::*;

    localparam int NUM_LOCKS   = LOCKS_DEFAULT;
    localparam int STACK_DEPTH = STACK_DEFAULT;
    localparam int RANDOM_ITEMS = 880;
    localparam int CALM_TAIL    = 100;

    typedef enum {FAULT_CYCLE, FAULT_FULL, FAULT_EMPTY, FAULT_MISMATCH} t_fault_kind;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_cmd     = CMD_ACQUIRE;
    logic [3:0] in_lock_id = 4'd0;
    logic       rx_stall   = 1'b0;
    logic       no_idle    = 1'b0;
    int         stall_left = 0;

    logic       dut_stall;
    logic       res_valid;
    logic [2:0] res_status;
    logic [3:0] res_from;
    logic [3:0] res_to;

    int unsigned fail_count;
    int unsigned waiting;
    int unsigned checked;

    logic [3:0]  held_q [$];
    logic [3:0]  order [NUM_LOCKS];
    int          rank [NUM_LOCKS];
    int          items_sent = 0;
    t_fault_kind fault;

    lock_order_deadlock_checker_top u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (dut_stall),
        .i_cmd        (in_cmd),
        .i_lock_id    (in_lock_id),
        .o_valid      (res_valid),
        .i_stall      (rx_stall),
        .o_status     (res_status),
        .o_cycle_from (res_from),
        .o_cycle_to   (res_to)
    );

    lod_order_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .i_in_stall   (dut_stall),
        .i_cmd        (in_cmd),
        .i_lock_id    (in_lock_id),
        .i_res_valid  (res_valid),
        .i_res_stall  (rx_stall),
        .i_status     (res_status),
        .i_cycle_from (res_from),
        .i_cycle_to   (res_to),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls at random, in bursts of random length
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_stall   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            rx_stall   <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            rx_stall   <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            rx_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic cmd, input logic [3:0] id);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_cmd     <= cmd;
        in_lock_id <= id;
        do @(posedge clk); while (dut_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic acquire(input logic [3:0] id);
        held_q.push_back(id);
        send_item(CMD_ACQUIRE, id);
    endtask

    task automatic release_top();
        logic [3:0] id;
        id = held_q.pop_back();
        send_item(CMD_RELEASE, id);
    endtask

    initial begin
        int         j;
        int         n;
        int         lo;
        int         a;
        int         b;
        int         acq_bias;
        int         anchor_pos [3];
        logic [3:0] tmp;
        logic [3:0] x;
        int         guard;

        // random global lock order; 0, 5 and 15 keep the order used by the directed items
        for (int k = 0; k < NUM_LOCKS; k++)
            order[k] = 4'(k);
        for (int k = NUM_LOCKS - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        n = 0;
        for (int k = 0; k < NUM_LOCKS; k++)
            if (order[k] == 4'd0 || order[k] == 4'd5 || order[k] == 4'd15) begin
                anchor_pos[n] = k;
                n++;
            end
        order[anchor_pos[0]] = 4'd0;
        order[anchor_pos[1]] = 4'd5;
        order[anchor_pos[2]] = 4'd15;
        for (int k = 0; k < NUM_LOCKS; k++)
            rank[order[k]] = k;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first push, recursive acquire, new edges, known edge, forward edge
        acquire(4'd0);
        acquire(4'd0);
        acquire(4'd5);
        acquire(4'd15);
        release_top();
        acquire(4'd15);
        release_top();
        release_top();
        acquire(4'd15);
        release_top();
        release_top();
        release_top();
        acquire(4'd15);
        release_top();

        // nested traffic that never breaks the lock order, so the block never halts here
        acq_bias = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - CALM_TAIL)
                no_idle <= 1'b1;
            else if (i % 64 == 0) begin
                acq_bias = $urandom_range(35, 75);
                no_idle <= ($urandom_range(0, 3) == 0);
            end
            if (i == 300) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (waiting != 0);
            end
            if (held_q.size() == 0 ||
                (held_q.size() < STACK_DEPTH && $urandom_range(0, 99) < acq_bias)) begin
                lo = (held_q.size() == 0) ? 0 : rank[held_q[$]];
                acquire(order[$urandom_range(lo, NUM_LOCKS - 1)]);
            end else begin
                release_top();
            end
        end
        while (held_q.size() != 0)
            release_top();

        // one fault per run, then items that only see the halted state
        fault = t_fault_kind'($urandom_range(0, 3));
        case (fault)
            FAULT_CYCLE: begin
                a = $urandom_range(0, NUM_LOCKS - 2);
                b = $urandom_range(a + 1, NUM_LOCKS - 1);
                acquire(order[a]);
                acquire(order[b]);
                release_top();
                release_top();
                acquire(order[b]);
                acquire(order[a]);
            end
            FAULT_FULL: begin
                for (int k = 0; k < STACK_DEPTH; k++)
                    acquire(order[k % NUM_LOCKS]);
                acquire(order[(STACK_DEPTH - 1) % NUM_LOCKS]);
            end
            FAULT_EMPTY: begin
                send_item(CMD_RELEASE, 4'($urandom_range(0, 15)));
            end
            FAULT_MISMATCH: begin
                x = 4'($urandom_range(0, 15));
                acquire(x);
                send_item(CMD_RELEASE, x ^ 4'($urandom_range(1, 15)));
            end
        endcase
        repeat (16)
            send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        in_valid <= 1'b0;

        guard = 0;
        while (waiting != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);

        $display("Covered %0d lock items: directed order cases, nested traffic over a random",
                 items_sent);
        $display("lock order, then a %s fault and halted items; %0d results checked.",
                 fault.name(), checked);
        if (waiting != 0)
            $display("%0d expected results never arrived", waiting);
        if (fail_count == 0 && waiting == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
